FILE: sv/cbm_pkg.sv
// Package: shared types and constants of the cartridge bank mapper.
`default_nettype none
package cbm_pkg;

  // Kind of access reported with each result beat
  typedef enum logic [2:0] {
    TGT_ROM     = 3'd0,
    TGT_RAM     = 3'd1,
    TGT_RAM_OFF = 3'd2,
    TGT_REG     = 3'd3,
    TGT_OUTSIDE = 3'd4
  } cbm_target_e;

  // Mapper register picked by address bits 14:13 on a write below 0x8000
  typedef enum logic [1:0] {
    REG_RAM_ENABLE = 2'd0,
    REG_LOW_BANK   = 2'd1,
    REG_UPPER_BANK = 2'd2,
    REG_MODE       = 2'd3
  } cbm_reg_e;

  localparam int unsigned AddrW     = 16;
  localparam int unsigned DataW     = 8;
  localparam int unsigned CountW    = 8;
  localparam int unsigned RomAddrW  = 21;
  localparam int unsigned RamAddrW  = 15;
  localparam int unsigned BankOffW  = 14;
  localparam int unsigned RamOffW   = 13;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 40;

  localparam logic [CountW-1:0] RomBankCountReset = 8'd2;
  localparam logic [3:0]        RamEnableKey      = 4'hA;

  // One translated access
  typedef struct packed {
    cbm_target_e          target;
    logic [RomAddrW-1:0]  rom_address;
    logic [RamAddrW-1:0]  ram_address;
    logic                 ram_write;
  } cbm_result_t;

endpackage
`default_nettype wire

FILE: sv/cbm_core.sv
// Bank registers and address translation of the mapper for one access.
`default_nettype none
module cbm_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        operation_i,
  input  wire logic [cbm_pkg::AddrW-1:0]   address_i,
  input  wire logic [cbm_pkg::DataW-1:0]   write_data_i,
  input  wire logic [cbm_pkg::CountW-1:0]  rom_bank_count_i,
  output cbm_pkg::cbm_result_t             result_o
);

  logic [3:0] ram_en_q,   ram_en_d;
  logic [4:0] low_bank_q, low_bank_d;
  logic [1:0] up_bank_q,  up_bank_d;
  logic [1:0] ram_sel_q,  ram_sel_d;
  logic       mode_q,     mode_d;

  logic [cbm_pkg::CountW-1:0] cnt_mask;
  logic [6:0]                 low_win_bank;
  logic [6:0]                 high_raw;
  logic [6:0]                 high_wrap;
  logic [6:0]                 high_bank;
  logic [6:0]                 up_probe;

  // Wrap a bank number that reaches the bank count
  function automatic logic [6:0] wrap_bank(input logic [6:0] bank,
                                           input logic [7:0] cnt,
                                           input logic [7:0] mask);
    logic [6:0] res;
    res = bank;
    if ({1'b0, bank} >= cnt) begin
      res = bank & mask[6:0];
    end
    return res;
  endfunction

  assign cnt_mask     = rom_bank_count_i - 8'd1;
  assign low_win_bank = wrap_bank({up_bank_q, 5'd0}, rom_bank_count_i, cnt_mask);
  assign high_raw     = {(mode_q ? 2'd0 : up_bank_q), low_bank_q & cnt_mask[4:0]};
  assign high_wrap    = wrap_bank(high_raw, rom_bank_count_i, cnt_mask);
  // Bank 128 drops out of the 21-bit ROM address, so keep seven bits
  assign high_bank    = high_wrap + {6'd0, (low_bank_q == 5'd0)};
  assign up_probe     = {write_data_i[1:0], low_bank_q};

  // Decode the access and work out the register updates
  always_comb begin
    ram_en_d   = ram_en_q;
    low_bank_d = low_bank_q;
    up_bank_d  = up_bank_q;
    ram_sel_d  = ram_sel_q;
    mode_d     = mode_q;
    result_o   = '{target: cbm_pkg::TGT_OUTSIDE, rom_address: '0,
                   ram_address: '0, ram_write: 1'b0};
    if (!address_i[15]) begin
      if (operation_i) begin
        result_o.target = cbm_pkg::TGT_REG;
        case (address_i[14:13])
          cbm_pkg::REG_RAM_ENABLE: ram_en_d   = write_data_i[3:0];
          cbm_pkg::REG_LOW_BANK:   low_bank_d = write_data_i[4:0];
          cbm_pkg::REG_UPPER_BANK: begin
            if (mode_q) begin
              ram_sel_d = write_data_i[1:0];
            end else if ({1'b0, up_probe} < rom_bank_count_i) begin
              up_bank_d = write_data_i[1:0];
            end
          end
          cbm_pkg::REG_MODE: mode_d = write_data_i[0];
          default: mode_d = mode_q;
        endcase
      end else begin
        result_o.target = cbm_pkg::TGT_ROM;
        if (!address_i[14]) begin
          result_o.rom_address = mode_q
            ? {low_win_bank, address_i[cbm_pkg::BankOffW-1:0]}
            : {7'd0, address_i[cbm_pkg::BankOffW-1:0]};
        end else begin
          result_o.rom_address = {high_bank, address_i[cbm_pkg::BankOffW-1:0]};
        end
      end
    end else if (address_i[15:13] == 3'b101) begin
      if (ram_en_q == cbm_pkg::RamEnableKey) begin
        result_o.target      = cbm_pkg::TGT_RAM;
        result_o.ram_address = {(mode_q ? ram_sel_q : 2'd0),
                                address_i[cbm_pkg::RamOffW-1:0]};
        result_o.ram_write   = operation_i;
      end else begin
        result_o.target = cbm_pkg::TGT_RAM_OFF;
      end
    end
  end

  // Commit register updates when the access moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_en_q   <= '0;
      low_bank_q <= '0;
      up_bank_q  <= '0;
      ram_sel_q  <= '0;
      mode_q     <= 1'b0;
    end else if (en_i) begin
      ram_en_q   <= ram_en_d;
      low_bank_q <= low_bank_d;
      up_bank_q  <= up_bank_d;
      ram_sel_q  <= ram_sel_d;
      mode_q     <= mode_d;
    end
  end

endmodule
`default_nettype wire

FILE: sv/cartridge_bank_mapper_unit.sv
// Top level of the cartridge bank mapper: stream ports, beat registers, count register.
//
// Each input beat is one CPU bus access (read or write) to the cartridge
// space; each output beat is the translated access: target kind in tuser,
// physical ROM address, cartridge RAM address and RAM write strobe in tdata.
// Writes below 0x8000 update the bank registers and report a register hit.
// Exactly one output beat leaves for every input beat, in order.
// Pipeline: input register, then translation, then result register; each
// result beat stays valid until taken. Throughput: one beat per cycle unless the
// receiver stalls, set by the single translation stage.
// The configuration channel carries the ROM bank count; it is always ready, and
// the user must write it only while no access is in flight, unchecked by the block.
// Reset clears the bank registers, sets the bank count to 2 and empties
// both beat registers. When the receiver stalls, the result register holds
// its beat, the input register fills, and then input tready drops until
// the output beat is taken.
`default_nettype none
module cartridge_bank_mapper_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // slave stream: tdata = {write_data[23:16], address[15:0]}
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [cbm_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser = operation[0]
  input  wire logic                          s_axis_tuser,
  // master stream: tdata = {3'b0, ram_write[36], ram_address[35:21], rom_address[20:0]}
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [cbm_pkg::OutDataW-1:0]       m_axis_tdata,
  // tuser = target[2:0]
  output logic [2:0]                         m_axis_tuser,
  // configuration channel: rom_bank_count
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [cbm_pkg::CountW-1:0]    cfg_data_i
);

  logic                          in_vld_q;
  logic                          in_op_q;
  logic [cbm_pkg::AddrW-1:0]     in_addr_q;
  logic [cbm_pkg::DataW-1:0]     in_wdata_q;
  logic                          out_vld_q;
  cbm_pkg::cbm_result_t          out_res_q;
  cbm_pkg::cbm_result_t          core_res;
  logic [cbm_pkg::CountW-1:0]    count_q;
  logic                          out_load;
  logic                          advance;
  logic                          in_fire;

  assign out_load      = !out_vld_q || m_axis_tready;
  assign advance       = in_vld_q && out_load;
  assign s_axis_tready = !in_vld_q || out_load;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Hold the bank count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= cbm_pkg::RomBankCountReset;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  // Input beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_op_q    <= s_axis_tuser;
      in_addr_q  <= s_axis_tdata[cbm_pkg::AddrW-1:0];
      in_wdata_q <= s_axis_tdata[cbm_pkg::AddrW +: cbm_pkg::DataW];
    end
  end

  cbm_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (advance),
    .operation_i      (in_op_q),
    .address_i        (in_addr_q),
    .write_data_i     (in_wdata_q),
    .rom_bank_count_i (count_q),
    .result_o         (core_res)
  );

  // Result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_res_q.target;
  assign m_axis_tdata  = {3'b000, out_res_q.ram_write, out_res_q.ram_address,
                          out_res_q.rom_address};

endmodule
`default_nettype wire

FILE: tb/tb_cartridge_bank_mapper_unit.sv
// Testbench for the cartridge bank mapper: directed and random bus accesses against a predictor.
`timescale 1ns / 1ps
module tb_cartridge_bank_mapper_unit;

  localparam int unsigned StallLimit = 3000;

  // Operation carried in s_axis_tuser
  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // Banking mode
  localparam logic ModeRom = 1'b0;
  localparam logic ModeRam = 1'b1;

  logic                         clk_i;
  logic                         rst_ni = 1'b0;
  logic                         s_tvalid = 1'b0;
  logic [cbm_pkg::InDataW-1:0]  s_tdata = '0;
  logic                         s_tuser = 1'b0;
  logic                         m_tready = 1'b0;
  logic                         cfg_valid = 1'b0;
  logic [cbm_pkg::CountW-1:0]   cfg_data = '0;
  logic                         s_axis_tready;
  logic                         m_axis_tvalid;
  logic [cbm_pkg::OutDataW-1:0] m_axis_tdata;
  logic [2:0]                   m_axis_tuser;
  logic                         cfg_ready_o;

  cartridge_bank_mapper_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data)
  );

  // Predictor copy of the mapper state
  logic [cbm_pkg::CountW-1:0] bank_count = cbm_pkg::RomBankCountReset;
  logic [3:0]                 ram_key    = '0;
  logic [4:0]                 low_bank   = '0;
  logic [1:0]                 upper_bank = '0;
  logic [1:0]                 ram_bank   = '0;
  logic                       bank_mode  = ModeRom;

  cbm_pkg::cbm_result_t mapped_q[$];
  cbm_pkg::cbm_result_t mapped_head;
  bit          idle_en = 1'b0;
  int unsigned rx_hold = 0;
  int unsigned rx_gap = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  int unsigned accesses_sent = 0;
  int unsigned count_writes = 0;
  int unsigned target_seen[5];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Wrap a bank that reaches the count, with an 8-bit mask
  function automatic int unsigned wrap_rom_bank(input int unsigned bank);
    int unsigned cnt;
    cnt = 32'(bank_count);
    if (bank >= cnt) bank &= (cnt - 1) & 'hFF;
    return bank;
  endfunction

  // Translate one access and update the bank registers it writes
  function automatic cbm_pkg::cbm_result_t translate_access(input logic op,
                                                            input logic [15:0] addr,
                                                            input logic [7:0] data);
    cbm_pkg::cbm_result_t res;
    int unsigned cnt;
    int unsigned bank;
    int unsigned full;
    res.target      = cbm_pkg::TGT_OUTSIDE;
    res.rom_address = '0;
    res.ram_address = '0;
    res.ram_write   = 1'b0;
    cnt = 32'(bank_count);
    if (addr < 16'h8000) begin
      if (op == OpWrite) begin
        res.target = cbm_pkg::TGT_REG;
        case (addr[14:13])
          cbm_pkg::REG_RAM_ENABLE: ram_key = data[3:0];
          cbm_pkg::REG_LOW_BANK:   low_bank = data[4:0];
          cbm_pkg::REG_UPPER_BANK: begin
            if (bank_mode == ModeRom) begin
              if (((int'(data[1:0]) << 5) | int'(low_bank)) < cnt) upper_bank = data[1:0];
            end else begin
              ram_bank = data[1:0];
            end
          end
          cbm_pkg::REG_MODE: bank_mode = data[0];
          default: bank_mode = bank_mode;
        endcase
      end else begin
        res.target = cbm_pkg::TGT_ROM;
        if (addr < 16'h4000) begin
          if (bank_mode == ModeRom) begin
            full = 32'(addr);
          end else begin
            bank = wrap_rom_bank(int'(upper_bank) << 5);
            full = bank * 'h4000 + 32'(addr);
          end
        end else begin
          bank = int'(low_bank) & ((cnt - 1) & 'h1F);
          if (bank_mode == ModeRom) bank |= int'(upper_bank) << 5;
          bank = wrap_rom_bank(bank);
          if (low_bank == 5'd0) bank += 1;
          full = bank * 'h4000 + (32'(addr) - 'h4000);
        end
        res.rom_address = full[cbm_pkg::RomAddrW-1:0];
      end
    end else if (addr >= 16'hA000 && addr < 16'hC000) begin
      if (ram_key == cbm_pkg::RamEnableKey) begin
        res.target      = cbm_pkg::TGT_RAM;
        res.ram_address = {2'b00, addr[cbm_pkg::RamOffW-1:0]};
        if (bank_mode == ModeRam) begin
          res.ram_address[cbm_pkg::RamAddrW-1:cbm_pkg::RamOffW] = ram_bank;
        end
        res.ram_write   = op;
      end else begin
        res.target = cbm_pkg::TGT_RAM_OFF;
      end
    end
    return res;
  endfunction

  // Offer one access after an optional gap; predict it once accepted
  task automatic send_access(input logic op, input logic [15:0] addr, input logic [7:0] data);
    int unsigned gap;
    gap = idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_tdata  = {data, addr};
    s_tuser  = op;
    s_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    mapped_q.push_back(translate_access(op, addr, data));
    accesses_sent++;
  endtask

  // Drop valid and hold until every predicted beat has come back
  task automatic wait_drain();
    @(negedge clk_i);
    s_tvalid = 1'b0;
    while (mapped_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_bank_count(input logic [cbm_pkg::CountW-1:0] count);
    wait_drain();
    @(negedge clk_i);
    cfg_data  = count;
    cfg_valid = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    bank_count = count;
    count_writes++;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // Mostly register set-up and window accesses, some noise anywhere on the bus
  task automatic random_access();
    int unsigned kind;
    logic        op;
    logic [15:0] addr;
    logic [7:0]  data;
    kind = $urandom_range(0, 99);
    op   = OpWrite;
    data = 8'($urandom_range(0, 255));
    if (kind < 10) begin
      addr = 16'($urandom_range(16'h0000, 16'h1FFF));
      if ($urandom_range(0, 9) < 6) data[3:0] = cbm_pkg::RamEnableKey;
    end else if (kind < 22) begin
      addr = 16'($urandom_range(16'h2000, 16'h3FFF));
    end else if (kind < 32) begin
      addr = 16'($urandom_range(16'h4000, 16'h5FFF));
    end else if (kind < 40) begin
      addr = 16'($urandom_range(16'h6000, 16'h7FFF));
    end else if (kind < 55) begin
      op   = OpRead;
      addr = 16'($urandom_range(16'h0000, 16'h3FFF));
    end else if (kind < 73) begin
      op   = OpRead;
      addr = 16'($urandom_range(16'h4000, 16'h7FFF));
    end else if (kind < 91) begin
      op   = 1'($urandom_range(0, 1));
      addr = 16'($urandom_range(16'hA000, 16'hBFFF));
    end else begin
      op   = 1'($urandom_range(0, 1));
      addr = 16'($urandom_range(0, 16'hFFFF));
    end
    send_access(op, addr, data);
  endtask

  task automatic test_reset_state();
    send_access(OpRead,  16'h0000, 8'h00);
    send_access(OpRead,  16'h4000, 8'hFF);
    send_access(OpRead,  16'h7FFF, 8'h00);
    send_access(OpRead,  16'hA000, 8'h00);
    send_access(OpWrite, 16'hBFFF, 8'hFF);
    send_access(OpRead,  16'h8000, 8'h00);
    send_access(OpRead,  16'hC000, 8'hFF);
    send_access(OpWrite, 16'hFFFF, 8'hFF);
  endtask

  // Upper bank accepted and refused, bank wrap in the high window, low bank zero
  task automatic test_bank_registers();
    write_bank_count(8'd128);
    send_access(OpWrite, 16'h2000, 8'hFF);
    send_access(OpWrite, 16'h4000, 8'h03);
    send_access(OpRead,  16'h7FFF, 8'h00);
    send_access(OpWrite, 16'h6000, 8'h01);
    send_access(OpRead,  16'h0000, 8'h00);
    send_access(OpWrite, 16'h7FFF, 8'hFE);
    write_bank_count(8'd32);
    send_access(OpRead,  16'h4000, 8'h00);
    send_access(OpWrite, 16'h5FFF, 8'h01);
    send_access(OpWrite, 16'h3FFF, 8'h00);
    send_access(OpRead,  16'h5000, 8'h00);
  endtask

  task automatic test_ram_window();
    send_access(OpWrite, 16'h1FFF, 8'h5A);
    send_access(OpRead,  16'hA000, 8'h00);
    send_access(OpWrite, 16'hBFFF, 8'h81);
    send_access(OpWrite, 16'h6000, 8'h01);
    send_access(OpWrite, 16'h4000, 8'h02);
    send_access(OpRead,  16'hB234, 8'h00);
    send_access(OpWrite, 16'h0000, 8'h00);
    send_access(OpRead,  16'hA123, 8'h00);
  endtask

  // Sweep the bank count over legal sizes and odd values, idling in most phases
  task automatic test_random_traffic();
    logic [cbm_pkg::CountW-1:0] counts[12];
    counts = '{8'd2, 8'd4, 8'd128, 8'd16, 8'd0, 8'd32, 8'd255, 8'd64, 8'd3, 8'd8, 8'd96, 8'd128};
    for (int phase = 0; phase < 12; phase++) begin
      write_bank_count(counts[phase]);
      idle_en = (phase % 3) != 0;
      repeat (40) random_access();
    end
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    idle_en = 1'b0;
    rx_hold = 120;
    repeat (30) random_access();
  endtask

  task automatic test_drain_pause();
    idle_en = 1'b1;
    repeat (12) random_access();
    wait_drain();
    repeat (12) random_access();
  endtask

  // Receiver: long hold when asked, random gaps when idling is on
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        m_tready = 1'b0;
        rx_hold--;
      end else if (rx_gap > 0) begin
        m_tready = 1'b0;
        rx_gap--;
      end else begin
        m_tready = 1'b1;
        rx_gap   = idle_en ? pick_gap() : 0;
      end
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_tready) begin
      if (m_axis_tuser <= cbm_pkg::TGT_OUTSIDE) target_seen[m_axis_tuser]++;
      if (mapped_q.size() == 0) begin
        $error("result beat with no access outstanding: tuser %0d tdata %h",
               m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        mapped_head = mapped_q.pop_front();
        if (m_axis_tuser != mapped_head.target) begin
          $error("target: expected %0d, got %0d", mapped_head.target, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[cbm_pkg::RomAddrW-1:0] != mapped_head.rom_address) begin
          $error("rom_address: expected %h, got %h", mapped_head.rom_address,
                 m_axis_tdata[cbm_pkg::RomAddrW-1:0]);
          mismatches++;
        end
        if (m_axis_tdata[cbm_pkg::RomAddrW +: cbm_pkg::RamAddrW] != mapped_head.ram_address)
        begin
          $error("ram_address: expected %h, got %h", mapped_head.ram_address,
                 m_axis_tdata[cbm_pkg::RomAddrW +: cbm_pkg::RamAddrW]);
          mismatches++;
        end
        if (m_axis_tdata[cbm_pkg::RomAddrW + cbm_pkg::RamAddrW] != mapped_head.ram_write) begin
          $error("ram_write: expected %0d, got %0d", mapped_head.ram_write,
                 m_axis_tdata[cbm_pkg::RomAddrW + cbm_pkg::RamAddrW]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long
  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready) ||
        (cfg_valid && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("tb_cartridge_bank_mapper_unit NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_state();
    test_bank_registers();
    test_ram_window();
    test_random_traffic();
    test_backpressure();
    test_drain_pause();
    wait_drain();
    repeat (8) @(posedge clk_i);
    $display("Ran %0d bus accesses over %0d bank count settings, with stalls on both sides.",
             accesses_sent, count_writes);
    $display("Results seen: ROM %0d, RAM %0d, RAM off %0d, register %0d, outside %0d.",
             target_seen[cbm_pkg::TGT_ROM], target_seen[cbm_pkg::TGT_RAM],
             target_seen[cbm_pkg::TGT_RAM_OFF], target_seen[cbm_pkg::TGT_REG],
             target_seen[cbm_pkg::TGT_OUTSIDE]);
    if (mismatches == 0) begin
      $display("tb_cartridge_bank_mapper_unit OK");
    end else begin
      $display("tb_cartridge_bank_mapper_unit NOT OK");
    end
    $finish;
  end

endmodule
